### hw/rtl/refraction_direction_top_macros.svh
// ----------------------------------------------------------------------------
// refraction direction assertion macros
// shared property forms for the refraction pipeline checks
// ----------------------------------------------------------------------------
`ifndef REFRACTION_DIRECTION_TOP_MACROS_SVH
`define REFRACTION_DIRECTION_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RFD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// payload types and fixed-point constants of the refraction direction block
// ----------------------------------------------------------------------------
package rfd_pkg;

	localparam int FRAC    = 14;          // fraction bits of the vector format
	localparam int VEC_W   = 16;
	localparam int IOR_W   = 14;
	localparam int NRM_W   = VEC_W + 1;   // negated normal needs one more bit
	localparam int PRD_W   = 2 * VEC_W + 1;
	localparam int DOT_W   = PRD_W + 2;
	localparam int C_W     = FRAC + 2;
	localparam int K_W     = 2 * FRAC + 1;
	localparam int KN_W    = K_W + IOR_W;
	localparam int NUM_W   = KN_W + IOR_W;
	localparam int DEN_W   = 2 * IOR_W;
	localparam int TQ_W    = 2 * FRAC;    // quotient bits of the radicand term
	localparam int DIV_N   = TQ_W;        // divider stages
	localparam int MT_W    = 19;
	localparam int AD_W    = MT_W + IOR_W;
	localparam int AQ_W    = AD_W - 12;   // divisor is at least 1.0 in Q2.12
	localparam int ASH_W   = AD_W + 2;
	localparam int A_W     = AQ_W + 1;
	localparam int SQ_W    = 2 * FRAC + 2;
	localparam int SQ_N    = FRAC + 1;    // root bits, one per stage
	localparam int BP_W    = NRM_W + SQ_N + 1;
	localparam int DIF_W   = A_W + 1;
	localparam int PIPE_DEPTH = 5 + (DIV_N + 1) + (SQ_N + 1) + 2;

	localparam logic [IOR_W-1:0] IOR_ONE = 14'd4096;

	typedef struct packed {
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] dir_z;
		logic signed [VEC_W-1:0] norm_x;
		logic signed [VEC_W-1:0] norm_y;
		logic signed [VEC_W-1:0] norm_z;
		logic                    inside_req;
		logic [IOR_W-1:0]        index_of_refraction;
	} ray_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] out_x;
		logic signed [VEC_W-1:0] out_y;
		logic signed [VEC_W-1:0] out_z;
		logic                    total_reflection;
	} result_t;

endpackage

### hw/rtl/refraction_direction_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refraction_direction_top
// snell refraction of a unit ray direction at a surface, fully pipelined
// throughput: one ray per cycle, busy stays low, results cannot be held off
// the depth is set by the 28-stage radicand divider and 15-stage square root
// reset clears the valid bits of every stage; payload registers are not reset
// ----------------------------------------------------------------------------
`include "refraction_direction_top_macros.svh"

module refraction_direction_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rfd_pkg::ray_t    ray,
	output logic             done,
	output rfd_pkg::result_t result
);

	// ---------------- stage 1: normal sign, index clamp, dot products
	logic [rfd_pkg::IOR_W-1:0]        ior_c;
	logic signed [rfd_pkg::VEC_W-1:0] d_in [3];
	logic signed [rfd_pkg::NRM_W-1:0] n_in [3];

	logic                             v_s1;
	logic signed [rfd_pkg::VEC_W-1:0] d_s1 [3];
	logic signed [rfd_pkg::NRM_W-1:0] n_s1 [3];
	logic signed [rfd_pkg::PRD_W-1:0] prod_s1 [3];
	logic [rfd_pkg::IOR_W-1:0]        n1_s1, n2_s1;

	always_comb begin
		ior_c = (ray.index_of_refraction < rfd_pkg::IOR_ONE) ? rfd_pkg::IOR_ONE
			: ray.index_of_refraction;
		d_in[0] = ray.dir_x;
		d_in[1] = ray.dir_y;
		d_in[2] = ray.dir_z;
		n_in[0] = {ray.norm_x[rfd_pkg::VEC_W-1], ray.norm_x};
		n_in[1] = {ray.norm_y[rfd_pkg::VEC_W-1], ray.norm_y};
		n_in[2] = {ray.norm_z[rfd_pkg::VEC_W-1], ray.norm_z};
		if (ray.inside_req) begin
			for (int i = 0; i < 3; i++) begin
				n_in[i] = -n_in[i];
			end
		end
	end

	// ---------------- stage 2: rounded, clamped cosine
	logic signed [rfd_pkg::DOT_W-1:0] dot;
	logic [rfd_pkg::DOT_W-1:0]        dmag, drm;
	logic [rfd_pkg::C_W-2:0]          cm;
	logic signed [rfd_pkg::C_W-1:0]   cs;

	logic                             v_s2;
	logic signed [rfd_pkg::VEC_W-1:0] d_s2 [3];
	logic signed [rfd_pkg::NRM_W-1:0] n_s2 [3];
	logic signed [rfd_pkg::C_W-1:0]   c_s2;
	logic [rfd_pkg::IOR_W-1:0]        n1_s2, n2_s2;
	logic [rfd_pkg::DEN_W-1:0]        den_s2;

	always_comb begin
		dot = rfd_pkg::DOT_W'(prod_s1[0]) + rfd_pkg::DOT_W'(prod_s1[1])
			+ rfd_pkg::DOT_W'(prod_s1[2]);
		dmag = dot[rfd_pkg::DOT_W-1] ? rfd_pkg::DOT_W'(-dot) : rfd_pkg::DOT_W'(dot);
		drm = (dmag + (rfd_pkg::DOT_W'(1) << (rfd_pkg::FRAC - 1))) >> rfd_pkg::FRAC;
		cm = (drm > (rfd_pkg::DOT_W'(1) << rfd_pkg::FRAC))
			? ((rfd_pkg::C_W - 1)'(1) << rfd_pkg::FRAC) : drm[rfd_pkg::C_W-2:0];
		cs = {1'b0, cm};
	end

	// ---------------- stage 3: 1 - c^2 and n*c
	logic signed [2*rfd_pkg::C_W-1:0] csq;

	logic                             v_s3;
	logic signed [rfd_pkg::VEC_W-1:0] d_s3 [3];
	logic signed [rfd_pkg::NRM_W-1:0] n_s3 [3];
	logic [rfd_pkg::K_W-1:0]          k_s3;
	logic signed [rfd_pkg::PRD_W-1:0] pn_s3 [3];
	logic [rfd_pkg::IOR_W-1:0]        n1_s3, n2_s3;
	logic [rfd_pkg::DEN_W-1:0]        den_s3;

	assign csq = c_s2 * c_s2;

	// ---------------- stage 4: k*n1, projection, tangential term
	logic [rfd_pkg::PRD_W-1:0]        pmag [3];
	logic [rfd_pkg::PRD_W-1:0]        prm [3];
	logic signed [rfd_pkg::MT_W:0]    proj [3];
	logic signed [rfd_pkg::MT_W:0]    term [3];

	logic                             v_s4;
	logic signed [rfd_pkg::NRM_W-1:0] n_s4 [3];
	logic [rfd_pkg::KN_W-1:0]         kn1_s4;
	logic [rfd_pkg::MT_W-1:0]         mt_s4 [3];
	logic                             tneg_s4 [3];
	logic [rfd_pkg::IOR_W-1:0]        n1_s4, n2_s4;
	logic [rfd_pkg::DEN_W-1:0]        den_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pmag[i] = pn_s3[i][rfd_pkg::PRD_W-1] ? rfd_pkg::PRD_W'(-pn_s3[i])
				: rfd_pkg::PRD_W'(pn_s3[i]);
			prm[i] = (pmag[i] + (rfd_pkg::PRD_W'(1) << (rfd_pkg::FRAC - 1))) >> rfd_pkg::FRAC;
			proj[i] = pn_s3[i][rfd_pkg::PRD_W-1] ? -$signed({1'b0, prm[i][rfd_pkg::MT_W-2:0]})
				: $signed({1'b0, prm[i][rfd_pkg::MT_W-2:0]});
			term[i] = (rfd_pkg::MT_W + 1)'(d_s3[i]) - proj[i];
		end
	end

	// ---------------- stage 5: radicand numerator and rounded-quotient dividends
	logic                             v_s5;
	logic signed [rfd_pkg::NRM_W-1:0] n_s5 [3];
	logic [rfd_pkg::NUM_W-1:0]        num_s5;
	logic [rfd_pkg::AD_W-1:0]         am_s5 [3];
	logic                             tneg_s5 [3];
	logic [rfd_pkg::IOR_W-1:0]        n2_s5;
	logic [rfd_pkg::DEN_W-1:0]        den_s5;

	// ---------------- divider stages, one quotient bit each
	logic [rfd_pkg::DIV_N:0]          div_v_s;
	logic [rfd_pkg::NUM_W-1:0]        div_rem_s [rfd_pkg::DIV_N+1];
	logic [rfd_pkg::DEN_W-1:0]        div_den_s [rfd_pkg::DIV_N+1];
	logic [rfd_pkg::TQ_W-1:0]         div_tq_s [rfd_pkg::DIV_N+1];
	logic                             div_refl_s [rfd_pkg::DIV_N+1];
	logic [rfd_pkg::IOR_W-1:0]        div_n2_s [rfd_pkg::DIV_N+1];
	logic [rfd_pkg::AD_W-1:0]         div_ar_s [rfd_pkg::DIV_N+1][3];
	logic [rfd_pkg::AQ_W-1:0]         div_aq_s [rfd_pkg::DIV_N+1][3];
	logic                             div_tneg_s [rfd_pkg::DIV_N+1][3];
	logic signed [rfd_pkg::NRM_W-1:0] div_n_s [rfd_pkg::DIV_N+1][3];

	logic [rfd_pkg::NUM_W-1:0]        div_dsh [rfd_pkg::DIV_N];
	logic                             div_tge [rfd_pkg::DIV_N];
	logic [rfd_pkg::ASH_W-1:0]        div_ash [rfd_pkg::DIV_N];
	logic                             div_age [rfd_pkg::DIV_N][3];

	always_comb begin
		for (int j = 0; j < rfd_pkg::DIV_N; j++) begin
			div_dsh[j] = {{(rfd_pkg::NUM_W - rfd_pkg::DEN_W){1'b0}}, div_den_s[j]}
				<< (rfd_pkg::DIV_N - 1 - j);
			div_tge[j] = div_rem_s[j] >= div_dsh[j];
			div_ash[j] = {{(rfd_pkg::ASH_W - rfd_pkg::IOR_W){1'b0}}, div_n2_s[j]}
				<< (rfd_pkg::DIV_N - 1 - j);
			for (int i = 0; i < 3; i++) begin
				div_age[j][i] = {2'b00, div_ar_s[j][i]} >= div_ash[j];
			end
		end
	end

	// ---------------- square root stages, one root bit each
	logic [rfd_pkg::SQ_N:0]           sqr_v_s;
	logic [rfd_pkg::SQ_W-1:0]         sqr_x_s [rfd_pkg::SQ_N+1];
	logic [rfd_pkg::SQ_W-1:0]         sqr_r_s [rfd_pkg::SQ_N+1];
	logic                             sqr_refl_s [rfd_pkg::SQ_N+1];
	logic signed [rfd_pkg::A_W-1:0]   sqr_a_s [rfd_pkg::SQ_N+1][3];
	logic signed [rfd_pkg::NRM_W-1:0] sqr_n_s [rfd_pkg::SQ_N+1][3];

	logic [rfd_pkg::SQ_W-1:0]         sqr_bit [rfd_pkg::SQ_N];
	logic [rfd_pkg::SQ_W-1:0]         sqr_t [rfd_pkg::SQ_N];
	logic                             sqr_ge [rfd_pkg::SQ_N];

	always_comb begin
		for (int j = 0; j < rfd_pkg::SQ_N; j++) begin
			sqr_bit[j] = rfd_pkg::SQ_W'(1) << (2 * (rfd_pkg::SQ_N - 1 - j));
			sqr_t[j] = sqr_r_s[j] + sqr_bit[j];
			sqr_ge[j] = sqr_x_s[j] >= sqr_t[j];
		end
	end

	// ---------------- final stages: n*sqrt(r), difference, saturation
	logic                             v_sf;
	logic                             refl_sf;
	logic signed [rfd_pkg::A_W-1:0]   a_sf [3];
	logic signed [rfd_pkg::BP_W-1:0]  bp_sf [3];

	logic [rfd_pkg::BP_W-1:0]         bmag [3];
	logic [rfd_pkg::BP_W-1:0]         brm [3];
	logic signed [rfd_pkg::DIF_W-1:0] bval [3];
	logic signed [rfd_pkg::DIF_W-1:0] dif [3];
	logic signed [rfd_pkg::VEC_W-1:0] sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bmag[i] = bp_sf[i][rfd_pkg::BP_W-1] ? rfd_pkg::BP_W'(-bp_sf[i])
				: rfd_pkg::BP_W'(bp_sf[i]);
			brm[i] = (bmag[i] + (rfd_pkg::BP_W'(1) << (rfd_pkg::FRAC - 1))) >> rfd_pkg::FRAC;
			bval[i] = bp_sf[i][rfd_pkg::BP_W-1] ? -$signed({1'b0, brm[i][rfd_pkg::DIF_W-2:0]})
				: $signed({1'b0, brm[i][rfd_pkg::DIF_W-2:0]});
			dif[i] = rfd_pkg::DIF_W'(a_sf[i]) - bval[i];
			if (dif[i] > rfd_pkg::DIF_W'(32767)) begin
				sat[i] = 16'sh7fff;
			end else if (dif[i] < -rfd_pkg::DIF_W'(32768)) begin
				sat[i] = -16'sh8000;
			end else begin
				sat[i] = dif[i][rfd_pkg::VEC_W-1:0];
			end
		end
	end

	assign busy = 1'b0;

	// ---------------- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			div_v_s <= '0;
			sqr_v_s <= '0;
			v_sf <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			div_v_s <= {div_v_s[rfd_pkg::DIV_N-1:0], v_s5};
			sqr_v_s <= {sqr_v_s[rfd_pkg::SQ_N-1:0], div_v_s[rfd_pkg::DIV_N]};
			v_sf <= sqr_v_s[rfd_pkg::SQ_N];
			done <= v_sf;
		end
	end

	// ---------------- datapath registers
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i] <= d_in[i];
			n_s1[i] <= n_in[i];
			prod_s1[i] <= n_in[i] * d_in[i];
		end
		n1_s1 <= ray.inside_req ? ior_c : rfd_pkg::IOR_ONE;
		n2_s1 <= ray.inside_req ? rfd_pkg::IOR_ONE : ior_c;

		d_s2 <= d_s1;
		n_s2 <= n_s1;
		c_s2 <= dot[rfd_pkg::DOT_W-1] ? -cs : cs;
		n1_s2 <= n1_s1;
		n2_s2 <= n2_s1;
		den_s2 <= n2_s1 * n2_s1;

		d_s3 <= d_s2;
		n_s3 <= n_s2;
		k_s3 <= {1'b1, {rfd_pkg::TQ_W{1'b0}}} - csq[rfd_pkg::K_W-1:0];
		for (int i = 0; i < 3; i++) begin
			pn_s3[i] <= n_s2[i] * c_s2;
		end
		n1_s3 <= n1_s2;
		n2_s3 <= n2_s2;
		den_s3 <= den_s2;

		n_s4 <= n_s3;
		kn1_s4 <= rfd_pkg::KN_W'(k_s3) * rfd_pkg::KN_W'(n1_s3);
		for (int i = 0; i < 3; i++) begin
			tneg_s4[i] <= term[i][rfd_pkg::MT_W];
			mt_s4[i] <= term[i][rfd_pkg::MT_W] ? rfd_pkg::MT_W'(-term[i])
				: rfd_pkg::MT_W'(term[i]);
		end
		n1_s4 <= n1_s3;
		n2_s4 <= n2_s3;
		den_s4 <= den_s3;

		n_s5 <= n_s4;
		num_s5 <= rfd_pkg::NUM_W'(kn1_s4) * rfd_pkg::NUM_W'(n1_s4);
		for (int i = 0; i < 3; i++) begin
			am_s5[i] <= rfd_pkg::AD_W'(mt_s4[i]) * rfd_pkg::AD_W'(n1_s4)
				+ rfd_pkg::AD_W'(n2_s4 >> 1);
		end
		tneg_s5 <= tneg_s4;
		n2_s5 <= n2_s4;
		den_s5 <= den_s4;

		// divider entry: a quotient of 2^28 or more is total reflection
		div_rem_s[0] <= num_s5;
		div_den_s[0] <= den_s5;
		div_tq_s[0] <= '0;
		div_refl_s[0] <= num_s5 >= {1'b0, den_s5, {rfd_pkg::TQ_W{1'b0}}};
		div_n2_s[0] <= n2_s5;
		for (int i = 0; i < 3; i++) begin
			div_ar_s[0][i] <= am_s5[i];
			div_aq_s[0][i] <= '0;
			div_tneg_s[0][i] <= tneg_s5[i];
			div_n_s[0][i] <= n_s5[i];
		end

		for (int j = 0; j < rfd_pkg::DIV_N; j++) begin
			div_rem_s[j+1] <= div_tge[j] ? div_rem_s[j] - div_dsh[j] : div_rem_s[j];
			div_tq_s[j+1] <= {div_tq_s[j][rfd_pkg::TQ_W-2:0], div_tge[j]};
			div_den_s[j+1] <= div_den_s[j];
			div_refl_s[j+1] <= div_refl_s[j];
			div_n2_s[j+1] <= div_n2_s[j];
			for (int i = 0; i < 3; i++) begin
				// the rounded quotient only has its low bits
				if (rfd_pkg::DIV_N - 1 - j < rfd_pkg::AQ_W) begin
					div_ar_s[j+1][i] <= div_age[j][i]
						? div_ar_s[j][i] - div_ash[j][rfd_pkg::AD_W-1:0] : div_ar_s[j][i];
					div_aq_s[j+1][i] <= {div_aq_s[j][i][rfd_pkg::AQ_W-2:0], div_age[j][i]};
				end else begin
					div_ar_s[j+1][i] <= div_ar_s[j][i];
					div_aq_s[j+1][i] <= div_aq_s[j][i];
				end
				div_tneg_s[j+1][i] <= div_tneg_s[j][i];
				div_n_s[j+1][i] <= div_n_s[j][i];
			end
		end

		// root entry: radicand is 1.0 minus the quotient
		sqr_x_s[0] <= {2'b01, {rfd_pkg::TQ_W{1'b0}}} - {2'b00, div_tq_s[rfd_pkg::DIV_N]};
		sqr_r_s[0] <= '0;
		sqr_refl_s[0] <= div_refl_s[rfd_pkg::DIV_N];
		for (int i = 0; i < 3; i++) begin
			sqr_a_s[0][i] <= div_tneg_s[rfd_pkg::DIV_N][i]
				? -$signed({1'b0, div_aq_s[rfd_pkg::DIV_N][i]})
				: $signed({1'b0, div_aq_s[rfd_pkg::DIV_N][i]});
			sqr_n_s[0][i] <= div_n_s[rfd_pkg::DIV_N][i];
		end

		for (int j = 0; j < rfd_pkg::SQ_N; j++) begin
			if (sqr_ge[j]) begin
				sqr_x_s[j+1] <= sqr_x_s[j] - sqr_t[j];
				sqr_r_s[j+1] <= (sqr_r_s[j] >> 1) + sqr_bit[j];
			end else begin
				sqr_x_s[j+1] <= sqr_x_s[j];
				sqr_r_s[j+1] <= sqr_r_s[j] >> 1;
			end
			sqr_refl_s[j+1] <= sqr_refl_s[j];
			sqr_a_s[j+1] <= sqr_a_s[j];
			sqr_n_s[j+1] <= sqr_n_s[j];
		end

		refl_sf <= sqr_refl_s[rfd_pkg::SQ_N];
		for (int i = 0; i < 3; i++) begin
			a_sf[i] <= sqr_a_s[rfd_pkg::SQ_N][i];
			bp_sf[i] <= sqr_n_s[rfd_pkg::SQ_N][i]
				* $signed({1'b0, sqr_r_s[rfd_pkg::SQ_N][rfd_pkg::SQ_N-1:0]});
		end

		result.total_reflection <= refl_sf;
		result.out_x <= refl_sf ? '0 : sat[0];
		result.out_y <= refl_sf ? '0 : sat[1];
		result.out_z <= refl_sf ? '0 : sat[2];
	end

	// ---------------- checks
	`RFD_ASSERT_SAME(a_refl_zero, done && result.total_reflection, result.out_x == 16'sd0 && result.out_y == 16'sd0 && result.out_z == 16'sd0, "reflected result not zero")
	`RFD_ASSERT_SAME(a_done_latency, done, $past(start && !busy, rfd_pkg::PIPE_DEPTH), "done without a start transfer")
	`RFD_ASSERT_NEXT(a_refl_carry, sqr_v_s[rfd_pkg::SQ_N] && sqr_refl_s[rfd_pkg::SQ_N], v_sf && refl_sf, "reflection flag lost")
	`RFD_ASSERT_SAME(a_root_range, sqr_v_s[rfd_pkg::SQ_N], sqr_r_s[rfd_pkg::SQ_N] <= 30'h4000, "root above one")

endmodule
